FILE: rtl/core/assert_macros.svh
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PLE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);
`else
`define PLE_ASSERT(lbl, prop, msg)
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/ple_pkg.sv
// types and constants of the positional list engine
package ple_pkg;
   localparam int CAPACITY = 256;
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int POS_W = 9;
   localparam int VALUE_W = 32;
   localparam int FOUND_W = 8;
   localparam int LENGTH_W = 9;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_FIND   = 2'd2,
      OP_CHANGE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BADPOS   = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;
endpackage

FILE: rtl/core/ple_req_if.sv
// request channel of the positional list engine
interface ple_req_if import ple_pkg::*;;
   logic                      valid;
   logic                      ready;
   op_type                    op;
   logic [POS_W-1:0]          position;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, op, position, value, input ready);
   modport sink (input valid, op, position, value, output ready);
endinterface

FILE: rtl/core/ple_rsp_if.sv
// response channel of the positional list engine
interface ple_rsp_if import ple_pkg::*;;
   logic                valid;
   logic                ready;
   status_type          status;
   logic [FOUND_W-1:0]  found_position;
   logic [LENGTH_W-1:0] list_length;

   modport source (output valid, status, found_position, list_length, input ready);
   modport sink (input valid, status, found_position, list_length, output ready);
endinterface

FILE: rtl/core/positional_list_engine.sv
// positional list engine: ordered list in one memory with insert, delete, find and change
//
// req_chan carries one item per request: op, position and value. rsp_chan returns
// one item per request: status, found_position and list_length.
// The list lives in a single synchronous ram with a registered read port; insert
// and delete move one entry per cycle through a read-then-write pipeline, and find
// compares one entry per cycle.
// One item is in work at a time. Change and any error go straight to the final state;
// insert moves entries up, from the end of the list down to the position; delete
// moves entries down, from the position to the end; and find scans from index zero
// until it meets a match or the end of the list.
// req_chan.ready is high while no request is in work, also while a finished
// response still waits in the output register; a stalled receiver holds the
// next result back in its final state until the output register frees.
// Reset clears the length to zero and drops any pending response; the ram
// contents are not cleared, and only entries below the current length are used.
`include "assert_macros.svh"
module positional_list_engine import ple_pkg::*; (
   input logic      clock,
   input logic      reset,
   ple_req_if.sink   req_chan,
   ple_rsp_if.source rsp_chan
);
   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_SEARCH,
      S_DONE
   } state_type;

   state_type            state_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [ADDR_W-1:0]    cursor_ff;
   logic [ADDR_W-1:0]    pos_ff;
   logic [VALUE_W-1:0]   val_ff;
   status_type           status_ff;
   logic [ADDR_W-1:0]    found_ff;
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [FOUND_W-1:0]   rsp_found_ff;
   logic [LENGTH_W-1:0]  rsp_length_ff;

   logic [VALUE_W-1:0]   mem [CAPACITY];
   logic [VALUE_W-1:0]   rd_data_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [VALUE_W-1:0]   mem_wr_data;
   logic [ADDR_W-1:0]    mem_rd_addr;

   logic                 req_fire;
   logic                 out_free;
   logic [COUNT_W-1:0]   cursor_next;
   logic                 last_entry;
   logic [COUNT_W-1:0]   req_pos;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign cursor_next = {1'b0, cursor_ff} + COUNT_W'(1);
   assign last_entry = (cursor_next == count_ff);
   assign req_pos = COUNT_W'(req_chan.position);

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.found_position = rsp_found_ff;
   assign rsp_chan.list_length = rsp_length_ff;

   always_comb begin
      mem_we = 1'b0;
      mem_wr_addr = cursor_ff;
      mem_wr_data = rd_data_ff;
      mem_rd_addr = ADDR_W'(cursor_next);
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.op)
                  OP_INSERT: mem_rd_addr = ADDR_W'(count_ff - COUNT_W'(1));
                  OP_DELETE: mem_rd_addr = ADDR_W'(req_pos + COUNT_W'(1));
                  OP_FIND: mem_rd_addr = '0;
                  OP_CHANGE: begin
                     mem_we = (req_pos < count_ff);
                     mem_wr_addr = ADDR_W'(req_chan.position);
                     mem_wr_data = req_chan.value;
                  end
                  default: mem_rd_addr = '0;
               endcase
            end
         end
         S_SHIFT_UP: begin
            mem_we = 1'b1;
            mem_wr_data = (cursor_ff == pos_ff) ? val_ff : rd_data_ff;
            mem_rd_addr = cursor_ff - ADDR_W'(2);
         end
         S_SHIFT_DOWN: begin
            mem_we = !last_entry;
            mem_rd_addr = cursor_ff + ADDR_W'(2);
         end
         S_SEARCH: mem_rd_addr = ADDR_W'(cursor_next);
         S_DONE: mem_rd_addr = cursor_ff;
         default: mem_rd_addr = cursor_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= mem[mem_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  pos_ff <= ADDR_W'(req_chan.position);
                  val_ff <= req_chan.value;
                  found_ff <= '0;
                  status_ff <= ST_OK;
                  state_ff <= S_DONE;
                  unique case (req_chan.op)
                     OP_INSERT: begin
                        if (req_pos > count_ff) begin
                           status_ff <= ST_BADPOS;
                        end else if (count_ff == COUNT_W'(CAPACITY)) begin
                           status_ff <= ST_FULL;
                        end else begin
                           cursor_ff <= ADDR_W'(count_ff);
                           state_ff <= S_SHIFT_UP;
                        end
                     end
                     OP_DELETE: begin
                        if (req_pos >= count_ff) begin
                           status_ff <= ST_BADPOS;
                        end else begin
                           cursor_ff <= ADDR_W'(req_chan.position);
                           state_ff <= S_SHIFT_DOWN;
                        end
                     end
                     OP_FIND: begin
                        if (count_ff == '0) begin
                           status_ff <= ST_NOTFOUND;
                        end else begin
                           cursor_ff <= '0;
                           state_ff <= S_SEARCH;
                        end
                     end
                     OP_CHANGE: begin
                        if (req_pos >= count_ff) begin
                           status_ff <= ST_BADPOS;
                        end
                     end
                     default: status_ff <= ST_BADPOS;
                  endcase
               end
            end
            S_SHIFT_UP: begin
               if (cursor_ff == pos_ff) begin
                  count_ff <= count_ff + COUNT_W'(1);
                  state_ff <= S_DONE;
               end else begin
                  cursor_ff <= cursor_ff - ADDR_W'(1);
               end
            end
            S_SHIFT_DOWN: begin
               if (last_entry) begin
                  count_ff <= count_ff - COUNT_W'(1);
                  state_ff <= S_DONE;
               end else begin
                  cursor_ff <= ADDR_W'(cursor_next);
               end
            end
            S_SEARCH: begin
               if (rd_data_ff == val_ff) begin
                  found_ff <= cursor_ff;
                  state_ff <= S_DONE;
               end else if (last_entry) begin
                  status_ff <= ST_NOTFOUND;
                  state_ff <= S_DONE;
               end else begin
                  cursor_ff <= ADDR_W'(cursor_next);
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_found_ff <= FOUND_W'(found_ff);
                  rsp_length_ff <= LENGTH_W'(count_ff);
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `PLE_ASSERT(a_count_bound, count_ff <= COUNT_W'(CAPACITY), "length above capacity")
   `PLE_ASSERT(a_count_source,
      (!$past(reset) && count_ff != $past(count_ff))
         |-> ($past(state_ff) == S_SHIFT_UP || $past(state_ff) == S_SHIFT_DOWN),
      "length changed outside a shift")
   `PLE_ASSERT(a_search_bound,
      (state_ff == S_SEARCH) |-> ({1'b0, cursor_ff} < count_ff),
      "search past the end of the list")
   `PLE_ASSERT(a_shift_down_bound,
      (state_ff == S_SHIFT_DOWN) |-> (cursor_next <= count_ff),
      "delete cursor past the end")
   `PLE_ASSERT_NEXT(a_done_delivers, (state_ff == S_DONE && out_free),
      (rsp_valid_ff && state_ff == S_IDLE), "finished item not delivered")
endmodule
